// ===== rtl/core/hrsp_pkg.sv =====
// Package for the HTTP request stream parser: phase codes, byte classes, key text, result type.
`timescale 1ns / 1ps
`default_nettype none
package hrsp_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int BODY_LEN_W      = 32;
    localparam int KEY_IDX_W       = 4;
    localparam logic [KEY_IDX_W-1:0] KEY_LEN = 4'd14;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] CLS_SKIP    = 3'd0;
    localparam logic [2:0] CLS_METHOD  = 3'd1;
    localparam logic [2:0] CLS_URI     = 3'd2;
    localparam logic [2:0] CLS_VERSION = 3'd3;
    localparam logic [2:0] CLS_KEY     = 3'd4;
    localparam logic [2:0] CLS_VALUE   = 3'd5;
    localparam logic [2:0] CLS_BODY    = 3'd6;

    typedef enum logic [9:0] {
        PH_METHOD     = 10'b00_0000_0001,
        PH_URI        = 10'b00_0000_0010,
        PH_VERSION    = 10'b00_0000_0100,
        PH_REQ_LF     = 10'b00_0000_1000,
        PH_LINE       = 10'b00_0001_0000,
        PH_LINE_LF    = 10'b00_0010_0000,
        PH_LINE_START = 10'b00_0100_0000,
        PH_BLANK_LF   = 10'b00_1000_0000,
        PH_BODY       = 10'b01_0000_0000,
        PH_ERROR      = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic [2:0]            byte_class;
        logic                  field_end;
        logic                  header_end;
        logic                  request_end;
        logic                  parse_error;
        logic                  has_length;
        logic [BODY_LEN_W-1:0] body_length;
    } result_t;

    // "Content-Length", one character per index
    function automatic logic [7:0] key_char(input logic [KEY_IDX_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hrsp_core.sv =====
// Parser state and the per-byte step logic of the HTTP request stream parser.
`timescale 1ns / 1ps
`default_nettype none
module hrsp_core #(
    parameter int LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire logic              cmd,
    input  wire logic [7:0]        in_byte,
    output hrsp_pkg::result_t      res
);

    localparam int PW = LENGTH_BITS + 4;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    hrsp_pkg::phase_t                   phase_reg, phase_next;
    logic [hrsp_pkg::KEY_IDX_W-1:0]     key_idx_reg, key_idx_next;
    logic                               key_mis_reg, key_mis_next;
    logic                               in_value_reg, in_value_next;
    logic                               skip_reg, skip_next;
    logic                               found_reg, found_next;
    logic                               digits_done_reg, digits_done_next;
    logic                               digit_seen_reg, digit_seen_next;
    logic [LENGTH_BITS-1:0]             accum_reg, accum_next;
    logic [LENGTH_BITS-1:0]             remain_reg, remain_next;

    logic       line_en;
    logic [2:0] cls;
    logic       fend, hend, rend;
    logic [3:0] digit;
    logic [PW-1:0] scaled;
    logic [63:0]   accum_wide;

    assign digit  = 4'(in_byte - hrsp_pkg::CH_ZERO);
    assign scaled = (PW'(accum_reg) << 3) + (PW'(accum_reg) << 1) + PW'(digit);

    always_comb begin
        phase_next       = phase_reg;
        key_idx_next     = key_idx_reg;
        key_mis_next     = key_mis_reg;
        in_value_next    = in_value_reg;
        skip_next        = skip_reg;
        found_next       = found_reg;
        digits_done_next = digits_done_reg;
        digit_seen_next  = digit_seen_reg;
        accum_next       = accum_reg;
        remain_next      = remain_reg;
        line_en          = 1'b0;
        cls              = hrsp_pkg::CLS_SKIP;
        fend             = 1'b0;
        hend             = 1'b0;
        rend             = 1'b0;
        accum_wide       = '0;
        res              = '0;

        case (phase_reg)
            hrsp_pkg::PH_METHOD: begin
                if (in_byte == hrsp_pkg::CH_SP) begin
                    fend       = 1'b1;
                    phase_next = hrsp_pkg::PH_URI;
                end else begin
                    cls = hrsp_pkg::CLS_METHOD;
                end
            end
            hrsp_pkg::PH_URI: begin
                if (in_byte == hrsp_pkg::CH_SP) begin
                    fend       = 1'b1;
                    phase_next = hrsp_pkg::PH_VERSION;
                end else begin
                    cls = hrsp_pkg::CLS_URI;
                end
            end
            hrsp_pkg::PH_VERSION: begin
                if (in_byte == hrsp_pkg::CH_CR) begin
                    fend       = 1'b1;
                    phase_next = hrsp_pkg::PH_REQ_LF;
                end else begin
                    cls = hrsp_pkg::CLS_VERSION;
                end
            end
            hrsp_pkg::PH_REQ_LF, hrsp_pkg::PH_LINE_LF: begin
                if (in_byte == hrsp_pkg::CH_LF) begin
                    key_idx_next  = '0;
                    key_mis_next  = 1'b0;
                    in_value_next = 1'b0;
                    skip_next     = 1'b0;
                    phase_next    = hrsp_pkg::PH_LINE_START;
                end else begin
                    phase_next = hrsp_pkg::PH_ERROR;
                end
            end
            hrsp_pkg::PH_LINE_START: begin
                // CR at line start opens the blank line, also with no header lines
                if (in_byte == hrsp_pkg::CH_CR) begin
                    phase_next = hrsp_pkg::PH_BLANK_LF;
                end else begin
                    phase_next = hrsp_pkg::PH_LINE;
                    line_en    = 1'b1;
                end
            end
            hrsp_pkg::PH_LINE: begin
                if (in_byte == hrsp_pkg::CH_CR) begin
                    fend       = 1'b1;
                    phase_next = hrsp_pkg::PH_LINE_LF;
                end else begin
                    line_en = 1'b1;
                end
            end
            hrsp_pkg::PH_BLANK_LF: begin
                if (in_byte != hrsp_pkg::CH_LF) begin
                    phase_next = hrsp_pkg::PH_ERROR;
                end else begin
                    hend = 1'b1;
                    if (found_reg && !digit_seen_reg) begin
                        phase_next = hrsp_pkg::PH_ERROR;
                    end else if (found_reg && accum_reg != '0) begin
                        remain_next = accum_reg;
                        phase_next  = hrsp_pkg::PH_BODY;
                    end else begin
                        rend = 1'b1;
                    end
                end
            end
            hrsp_pkg::PH_BODY: begin
                cls         = hrsp_pkg::CLS_BODY;
                remain_next = remain_reg - 1'b1;
                if (remain_next == '0) begin
                    rend = 1'b1;
                end
            end
            default: begin
                phase_next = hrsp_pkg::PH_ERROR;
            end
        endcase

        // header line byte other than CR
        if (line_en) begin
            if (!in_value_reg) begin
                if (in_byte == hrsp_pkg::CH_COLON) begin
                    in_value_next = 1'b1;
                    skip_next     = 1'b1;
                    if (!key_mis_reg && key_idx_reg == hrsp_pkg::KEY_LEN && !found_reg) begin
                        found_next = 1'b1;
                    end else begin
                        key_mis_next = 1'b1;
                    end
                end else begin
                    cls = hrsp_pkg::CLS_KEY;
                    if (!key_mis_reg && key_idx_reg < hrsp_pkg::KEY_LEN &&
                        in_byte == hrsp_pkg::key_char(key_idx_reg)) begin
                        key_idx_next = key_idx_reg + 1'b1;
                    end else begin
                        key_mis_next = 1'b1;
                    end
                end
            end else if (skip_reg) begin
                skip_next = 1'b0;
            end else begin
                cls = hrsp_pkg::CLS_VALUE;
                if (!key_mis_reg && !digits_done_reg) begin
                    if (in_byte inside {[hrsp_pkg::CH_ZERO:hrsp_pkg::CH_NINE]}) begin
                        if (scaled > PW'(LEN_MAX)) begin
                            accum_next = LEN_MAX;
                        end else begin
                            accum_next = scaled[LENGTH_BITS-1:0];
                        end
                        digit_seen_next = 1'b1;
                    end else begin
                        digits_done_next = 1'b1;
                    end
                end
            end
        end

        accum_wide = 64'(accum_next);
        if (!cmd) begin
            res.out_byte    = in_byte;
            res.byte_class  = cls;
            res.field_end   = fend;
            res.header_end  = hend;
            res.request_end = rend;
            res.parse_error = (phase_next == hrsp_pkg::PH_ERROR);
            res.has_length  = found_next;
            res.body_length = (|accum_wide[63:32]) ? '1 : accum_wide[31:0];
        end

        if (cmd || rend) begin
            phase_next       = hrsp_pkg::PH_METHOD;
            key_idx_next     = '0;
            key_mis_next     = 1'b0;
            in_value_next    = 1'b0;
            skip_next        = 1'b0;
            found_next       = 1'b0;
            digits_done_next = 1'b0;
            digit_seen_next  = 1'b0;
            accum_next       = '0;
            remain_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= hrsp_pkg::PH_METHOD;
            key_idx_reg     <= '0;
            key_mis_reg     <= 1'b0;
            in_value_reg    <= 1'b0;
            skip_reg        <= 1'b0;
            found_reg       <= 1'b0;
            digits_done_reg <= 1'b0;
            digit_seen_reg  <= 1'b0;
            accum_reg       <= '0;
            remain_reg      <= '0;
        end else if (step_en) begin
            phase_reg       <= phase_next;
            key_idx_reg     <= key_idx_next;
            key_mis_reg     <= key_mis_next;
            in_value_reg    <= in_value_next;
            skip_reg        <= skip_next;
            found_reg       <= found_next;
            digits_done_reg <= digits_done_next;
            digit_seen_reg  <= digit_seen_next;
            accum_reg       <= accum_next;
            remain_reg      <= remain_next;
        end
    end

`ifndef SYNTHESIS
    a_body_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == hrsp_pkg::PH_BODY |-> remain_reg != '0)
        else $error("body phase with no bytes remaining");

    a_key_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        key_idx_reg <= hrsp_pkg::KEY_LEN)
        else $error("key match index past key length");

    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.request_end |=> phase_reg == hrsp_pkg::PH_METHOD && !found_reg)
        else $error("parser did not restart after request end");

    a_end_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.request_end |-> !res.parse_error)
        else $error("request end flagged together with error");

    a_body_class: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && !cmd && phase_reg == hrsp_pkg::PH_BODY |-> res.byte_class == hrsp_pkg::CLS_BODY)
        else $error("body beat not tagged as body");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/http_request_stream_parser_top.sv =====
// Top level of the HTTP request stream parser: stream ports, input and result registers.
//
// Usage: one request byte per input beat on the s_ channel; s_tuser[0] = 1 is a
// restart command (byte ignored, result beat all zero). Each input beat gives
// exactly one result beat on the m_ channel carrying the byte, its class in
// m_tuser, field/header end flags, the sticky error, and the Content-Length
// seen so far. m_tlast marks the beat that completes a request.
// Path: a beat taken on s_ passes the input register, then the parse step
// into the result register, and is then presented on m_.
// Throughput: one beat per cycle while m_ is not stalled; the parse step is
// combinational on the parser state registers.
// Reset (aresetn low, synchronous): both register stages empty, parser back to
// the method phase with no length seen.
// Stall: when m_tready is low the result beat holds; the input register still
// takes one more beat, then s_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module http_request_stream_parser_top #(
    parameter int LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic [0:0]  s_tuser,   // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] out_byte, [8] field_end, [9] header_end,
                                        // [10] parse_error, [11] has_length,
                                        // [43:12] body_length, [47:44] zero
    output logic [2:0]       m_tuser,   // [2:0] byte_class
    output logic             m_tlast    // request_end
);

    logic                in_valid_reg, in_valid_next;
    logic                in_cmd_reg;
    logic [7:0]          in_byte_reg;
    logic                out_valid_reg, out_valid_next;
    hrsp_pkg::result_t   out_res_reg;
    hrsp_pkg::result_t   step_res;
    logic                advance;
    logic                s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg  <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    hrsp_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .cmd     (in_cmd_reg),
        .in_byte (in_byte_reg),
        .res     (step_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       out_res_reg.body_length,
                       out_res_reg.has_length,
                       out_res_reg.parse_error,
                       out_res_reg.header_end,
                       out_res_reg.field_end,
                       out_res_reg.out_byte};
    assign m_tuser  = out_res_reg.byte_class;
    assign m_tlast  = out_res_reg.request_end;

endmodule
`default_nettype wire

// ===== sim/tb_http_request_stream_parser_top.sv =====
// Self-checking testbench for the HTTP request stream parser: random requests, gaps, stalls.
`timescale 1ns / 1ps
module tb_http_request_stream_parser_top;
    import hrsp_pkg::*;

    localparam int ITEM_TARGET = 1050;
    localparam int IDLE_LIMIT  = 2000;
    localparam int BODY_CAP    = 64;

    // Tracks the parser state and the results it must produce, in order.
    class parse_scoreboard;
        localparam logic [111:0] LEN_KEY_TEXT = "Content-Length";

        phase_t      phase;
        logic [3:0]  key_idx;
        bit          key_miss;
        bit          in_val;
        bit          skip_next;
        bit          len_found;
        bit          digits_stop;
        bit          digit_seen;
        logic [31:0] len_acc;
        logic [31:0] body_left;
        result_t     expected_q[$];
        int          errors;

        function new();
            errors = 0;
            clear_all();
        endfunction

        function void clear_line();
            key_idx   = '0;
            key_miss  = 1'b0;
            in_val    = 1'b0;
            skip_next = 1'b0;
        endfunction

        function void clear_all();
            phase       = PH_METHOD;
            clear_line();
            len_found   = 1'b0;
            digits_stop = 1'b0;
            digit_seen  = 1'b0;
            len_acc     = '0;
            body_left   = '0;
        endfunction

        function logic [7:0] key_at(logic [3:0] idx);
            return LEN_KEY_TEXT[8*(KEY_LEN-1-idx) +: 8];
        endfunction

        // byte of a header line other than CR
        function logic [2:0] header_line_byte(logic [7:0] c);
            logic [63:0] d;
            if (!in_val) begin
                if (c == CH_COLON) begin
                    in_val    = 1'b1;
                    skip_next = 1'b1;
                    if (!key_miss && key_idx == KEY_LEN && !len_found)
                        len_found = 1'b1;
                    else
                        key_miss = 1'b1;
                    return CLS_SKIP;
                end
                if (!key_miss && key_idx < KEY_LEN && c == key_at(key_idx))
                    key_idx = key_idx + 1'b1;
                else
                    key_miss = 1'b1;
                return CLS_KEY;
            end
            if (skip_next) begin
                skip_next = 1'b0;
                return CLS_SKIP;
            end
            if (!key_miss && !digits_stop) begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    d = 64'(c - CH_ZERO);
                    if ({32'd0, len_acc} > (64'hFFFF_FFFF - d) / 10)
                        len_acc = '1;
                    else
                        len_acc = 32'({32'd0, len_acc} * 10 + d);
                    digit_seen = 1'b1;
                end else begin
                    digits_stop = 1'b1;
                end
            end
            return CLS_VALUE;
        endfunction

        function void note_input(bit cmd, logic [7:0] c);
            result_t    r;
            logic [2:0] cls;
            bit         fend, hend, rend;
            r    = '0;
            cls  = CLS_SKIP;
            fend = 1'b0;
            hend = 1'b0;
            rend = 1'b0;
            if (cmd) begin
                clear_all();
                expected_q = {expected_q, r};
                return;
            end
            case (phase)
                PH_METHOD: begin
                    if (c == CH_SP) begin
                        fend  = 1'b1;
                        phase = PH_URI;
                    end else cls = CLS_METHOD;
                end
                PH_URI: begin
                    if (c == CH_SP) begin
                        fend  = 1'b1;
                        phase = PH_VERSION;
                    end else cls = CLS_URI;
                end
                PH_VERSION: begin
                    if (c == CH_CR) begin
                        fend  = 1'b1;
                        phase = PH_REQ_LF;
                    end else cls = CLS_VERSION;
                end
                PH_REQ_LF, PH_LINE_LF: begin
                    if (c == CH_LF) begin
                        clear_line();
                        phase = PH_LINE_START;
                    end else phase = PH_ERROR;
                end
                PH_LINE_START: begin
                    if (c == CH_CR) begin
                        phase = PH_BLANK_LF;
                    end else begin
                        phase = PH_LINE;
                        cls   = header_line_byte(c);
                    end
                end
                PH_LINE: begin
                    if (c == CH_CR) begin
                        fend  = 1'b1;
                        phase = PH_LINE_LF;
                    end else cls = header_line_byte(c);
                end
                PH_BLANK_LF: begin
                    if (c != CH_LF) begin
                        phase = PH_ERROR;
                    end else begin
                        hend = 1'b1;
                        if (len_found && !digit_seen) begin
                            phase = PH_ERROR;
                        end else if (len_found && len_acc != 0) begin
                            body_left = len_acc;
                            phase     = PH_BODY;
                        end else rend = 1'b1;
                    end
                end
                PH_BODY: begin
                    cls       = CLS_BODY;
                    body_left = body_left - 1'b1;
                    if (body_left == 0) rend = 1'b1;
                end
                default: phase = PH_ERROR;
            endcase
            r.out_byte    = c;
            r.byte_class  = cls;
            r.field_end   = fend;
            r.header_end  = hend;
            r.request_end = rend;
            r.parse_error = (phase == PH_ERROR);
            r.has_length  = len_found;
            r.body_length = len_acc;
            expected_q = {expected_q, r};
            if (rend) clear_all();
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 40)
                $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
                         $time, what, got, want);
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("beat with nothing expected", 32'(got.out_byte), 32'd0);
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
            if (got.byte_class !== want.byte_class)
                report_mismatch("byte_class", 32'(got.byte_class), 32'(want.byte_class));
            if (got.field_end !== want.field_end)
                report_mismatch("field_end", 32'(got.field_end), 32'(want.field_end));
            if (got.header_end !== want.header_end)
                report_mismatch("header_end", 32'(got.header_end), 32'(want.header_end));
            if (got.request_end !== want.request_end)
                report_mismatch("request_end", 32'(got.request_end),
                                32'(want.request_end));
            if (got.parse_error !== want.parse_error)
                report_mismatch("parse_error", 32'(got.parse_error),
                                32'(want.parse_error));
            if (got.has_length !== want.has_length)
                report_mismatch("has_length", 32'(got.has_length), 32'(want.has_length));
            if (got.body_length !== want.body_length)
                report_mismatch("body_length", got.body_length, want.body_length);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    parse_scoreboard sb = new();
    result_t         seen;
    logic [7:0]      req_q[$];
    bit              calm = 1'b0;
    int              beats_sent = 0;
    int              idle_cycles = 0;

    http_request_stream_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void append_byte(logic [7:0] b);
        req_q = {req_q, b};
    endfunction

    function automatic logic [7:0] rand_byte_not(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        do r = 8'($urandom_range(0, 255)); while (r == a || r == b);
        return r;
    endfunction

    function automatic void push_run(int lo, int hi, logic [7:0] a, logic [7:0] b);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) append_byte(rand_byte_not(a, b));
    endfunction

    function automatic void push_text(string s);
        foreach (s[i]) append_byte(s[i]);
    endfunction

    function automatic void push_header();
        int pick;
        int val;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            push_text("Content-Length");
        end else if (pick < 6) begin
            case ($urandom_range(0, 4))
                0: push_text("Content-Lengt");
                1: push_text("Content-Lengthh");
                2: push_text("content-length");
                3: push_text("ContentLength");
                default: push_text("Content-Type");
            endcase
        end else begin
            push_run(1, 10, CH_COLON, CH_CR);
        end
        // no colon: the whole line is key bytes
        if ($urandom_range(0, 9) == 0) begin
            append_byte(CH_CR);
            append_byte(CH_LF);
            return;
        end
        append_byte(CH_COLON);
        append_byte(($urandom_range(0, 4) != 0) ? CH_SP : rand_byte_not(CH_CR, CH_CR));
        val = $urandom_range(0, 19);
        if (val < 14) begin
            if ($urandom_range(0, 4) == 0) push_text("00");
            if (val < 2) push_text("0");
            else if (val < 12) push_text($sformatf("%0d", $urandom_range(1, 12)));
            else push_text($sformatf("%0d", $urandom_range(13, BODY_CAP)));
        end else if (val == 14) begin
            push_text("x");
            push_run(0, 3, CH_CR, CH_CR);
        end else if (val == 15) begin
            push_text("9");
            repeat ($urandom_range(9, 12)) append_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end else begin
            push_run(0, 8, CH_CR, CH_CR);
        end
        if ($urandom_range(0, 2) == 0) begin
            push_text(";");
            push_run(0, 4, CH_CR, CH_CR);
        end
        append_byte(CH_CR);
        append_byte(CH_LF);
    endfunction

    function automatic void push_request_line();
        push_run(1, 6, CH_SP, CH_SP);
        append_byte(CH_SP);
        push_run(1, 8, CH_SP, CH_SP);
        append_byte(CH_SP);
        push_run(1, 8, CH_CR, CH_CR);
        append_byte(CH_CR);
    endfunction

    task automatic send_beat(bit cmd, logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(cmd, b);
        beats_sent++;
    endtask

    task automatic send_restart();
        send_beat(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_queue();
        while (req_q.size() > 0) send_beat(1'b0, req_q.pop_front());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic send_request();
        int n;
        int idx;
        req_q.delete();
        push_request_line();
        append_byte(CH_LF);
        n = $urandom_range(0, 4);
        repeat (n) push_header();
        // broken CR/LF pair somewhere in the header
        if ($urandom_range(0, 9) == 0) begin
            idx = $urandom_range(0, req_q.size() - 2);
            while (idx < req_q.size() - 1 && req_q[idx] != CH_CR) idx++;
            if (idx < req_q.size() - 1) req_q[idx+1] = rand_byte_not(CH_LF, CH_LF);
        end
        // abort mid-request
        if ($urandom_range(0, 19) == 0) begin
            n = $urandom_range(0, req_q.size() - 1);
            while (req_q.size() > n) void'(req_q.pop_back());
            send_queue();
            send_restart();
            return;
        end
        send_queue();
        if (sb.phase != PH_LINE_START || sb.len_acc > BODY_CAP) return;
        send_beat(1'b0, CH_CR);
        if ($urandom_range(0, 19) == 0) begin
            send_beat(1'b0, rand_byte_not(CH_LF, CH_LF));
            return;
        end
        send_beat(1'b0, CH_LF);
        while (sb.phase == PH_BODY) send_beat(1'b0, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if (pick_gap() > 0) begin
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen.out_byte    = m_tdata[7:0];
            seen.byte_class  = m_tuser;
            seen.field_end   = m_tdata[8];
            seen.header_end  = m_tdata[9];
            seen.request_end = m_tlast;
            seen.parse_error = m_tdata[10];
            seen.has_length  = m_tdata[11];
            seen.body_length = m_tdata[43:12];
            sb.check_result(seen);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: restart, extreme bytes with no header lines, CR without LF, error phase
        send_restart();
        req_q = '{8'hFF, CH_SP, 8'h00, CH_SP, 8'h80, CH_CR, CH_LF, CH_CR, CH_LF};
        send_queue();
        push_text("M U V");
        append_byte(CH_CR);
        push_text("Q");
        append_byte(8'h7F);
        send_queue();
        send_restart();
        drain();

        while (beats_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 7) == 0);
            if (sb.phase != PH_METHOD || $urandom_range(0, 19) == 0) send_restart();
            case ($urandom_range(0, 19))
                16, 17: begin
                    push_run(1, 12, CH_CR, CH_CR);
                    push_run(0, 4, 8'h00, 8'h00);
                    send_queue();
                end
                18, 19: begin
                    push_request_line();
                    append_byte(rand_byte_not(CH_LF, CH_LF));
                    repeat ($urandom_range(0, 4)) append_byte(8'($urandom_range(0, 255)));
                    send_queue();
                end
                default: send_request();
            endcase
            if ($urandom_range(0, 24) == 0) drain();
        end

        s_tvalid <= 1'b0;
        calm = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
